>>> hdl/kpb_pkg.sv
package kpb_pkg;

    // defaults for the top-level parameters
    localparam int MAP_BITS_DEF = 65536;
    localparam int MAX_KMER_DEF = 16;

    // widest byte address the map can need (MAP_BITS up to 2**20)
    localparam int ADDR_MAX_W = 17;

    // register reset values
    localparam logic [4:0]  KMER_LEN_RST = 5'd8;
    localparam logic [15:0] CAP_RST      = 16'hffff;

    // register indexes, taken from paddr[2]
    localparam logic REG_KMER_LENGTH = 1'b0;
    localparam logic REG_CAPACITY    = 1'b1;

    // code for a byte that is not a base
    localparam logic [2:0] BASE_SKIP = 3'b100;

    typedef enum logic [1:0] {
        KIND_BASE  = 2'd0,
        KIND_TEST  = 2'd1,
        KIND_SET   = 2'd2,
        KIND_CLEAR = 2'd3
    } t_kind;

    // operation the back end carries out on the bitmap
    typedef enum logic [1:0] {
        OP_NONE  = 2'd0,
        OP_TEST  = 2'd1,
        OP_SET   = 2'd2,
        OP_CLEAR = 2'd3
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [ADDR_MAX_W-1:0] addr;
        logic [2:0]            bit_pos;
        logic                  in_range;
        logic [31:0]           kmer_code;
        logic                  complete;
    } t_job;

    typedef struct packed {
        logic        bit_value;
        logic        in_range;
        logic [31:0] kmer_code;
        logic        complete;
    } t_result;

    // nt4 table: bit 2 set means the byte is skipped
    function automatic logic [2:0] base_code(input logic [7:0] sym);
        logic [2:0] c;
        unique case (sym)
            8'd0, 8'h41, 8'h61:               c = 3'd0;
            8'd1, 8'h43, 8'h63:               c = 3'd1;
            8'd2, 8'h47, 8'h67:               c = 3'd2;
            8'd3, 8'h54, 8'h74, 8'h55, 8'h75: c = 3'd3;
            default:                          c = BASE_SKIP;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/kpb_queue.sv
module kpb_queue
    import kpb_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_data,
    output logic o_full,
    output logic o_empty,
    input  logic i_pop,
    output t_job o_data
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    // two-entry job queue between front and back
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    // payload storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

>>> hdl/kpb_front.sv
module kpb_front
    import kpb_pkg::*;
#(
    parameter int MAP_BITS = MAP_BITS_DEF,
    parameter int MAX_KMER = MAX_KMER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_accept,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_symbol,
    input  logic        i_first_of_sequence,
    input  logic [15:0] i_bit_index,
    input  logic [4:0]  i_kmer_length,
    input  logic [15:0] i_capacity_bits,
    output t_job        o_job
);

    localparam int WW        = 2 * MAX_KMER;
    localparam int KW        = $clog2(MAX_KMER + 1);
    localparam int CW        = (WW > 32) ? WW : 32;
    localparam int MAP_BYTES = MAP_BITS / 8;
    localparam logic [5:0] KMAX = 6'(MAX_KMER);

    logic [WW-1:0] r_window;
    logic [KW-1:0] r_seen;
    logic [WW-1:0] n_window;
    logic [KW-1:0] n_seen;

    t_kind         kind;
    logic [5:0]    kl6;
    logic [5:0]    k6;
    logic [KW-1:0] k;
    logic [WW-1:0] mask;
    logic [WW-1:0] fr_w;
    logic [KW-1:0] fr_seen;
    logic [2:0]    code;
    logic          is_base;
    logic [WW-1:0] w_shift;
    logic [KW-1:0] seen_step;
    logic          formed;
    logic [CW-1:0] val;
    logic [CW-1:0] byte_idx;
    logic          rng;
    logic [CW-1:0] w_ext;

    assign kind = t_kind'(i_kind);

    // effective k, clamped to 1..MAX_KMER
    assign kl6 = {1'b0, i_kmer_length};
    assign k6  = (kl6 == 6'd0) ? 6'd1 : ((kl6 > KMAX) ? KMAX : kl6);
    assign k   = k6[KW-1:0];
    assign mask = ~({WW{1'b1}} << {k6, 1'b0});

    // window update for a base word, other words keep the window
    assign fr_w    = (kind == KIND_BASE && i_first_of_sequence) ? '0 : r_window;
    assign fr_seen = (kind == KIND_BASE && i_first_of_sequence) ? '0 : r_seen;
    assign code    = base_code(i_symbol);
    assign is_base = (code != BASE_SKIP);
    assign w_shift = ((fr_w << 2) | WW'(code[1:0])) & mask;
    assign seen_step = (fr_seen < k) ? KW'(fr_seen + 1'b1) : fr_seen;
    assign n_window  = (kind == KIND_BASE && is_base) ? w_shift : fr_w;
    assign n_seen    = is_base ? seen_step : fr_seen;
    assign formed    = (kind == KIND_BASE) && is_base && (seen_step >= k);

    // byte range check shared by k-mers and index words
    assign w_ext    = CW'(n_window);
    assign val      = (kind == KIND_BASE) ? w_ext : CW'(i_bit_index);
    assign byte_idx = val >> 3;
    assign rng      = (byte_idx <= CW'(i_capacity_bits[15:3]))
                   && (byte_idx < CW'(MAP_BYTES));

    // classify the word into a bitmap job
    always_comb begin
        o_job           = '0;
        o_job.addr      = byte_idx[ADDR_MAX_W-1:0];
        o_job.bit_pos   = val[2:0];
        o_job.kmer_code = w_ext[31:0];
        unique case (kind)
            KIND_BASE: begin
                o_job.op       = (formed && rng) ? OP_SET : OP_NONE;
                o_job.in_range = formed && rng;
                o_job.complete = formed && rng;
            end
            KIND_TEST: begin
                o_job.op       = rng ? OP_TEST : OP_NONE;
                o_job.in_range = rng;
            end
            KIND_SET: begin
                o_job.op       = rng ? OP_SET : OP_NONE;
                o_job.in_range = rng;
            end
            KIND_CLEAR: begin
                o_job.op       = rng ? OP_CLEAR : OP_NONE;
                o_job.in_range = rng;
            end
            default: begin
                o_job.op = OP_NONE;
            end
        endcase
    end

    // window and base count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= '0;
            r_seen   <= '0;
        end else if (i_valid && i_accept && kind == KIND_BASE) begin
            r_window <= n_window;
            r_seen   <= n_seen;
        end
    end

endmodule

>>> hdl/kpb_back.sv
module kpb_back
    import kpb_pkg::*;
#(
    parameter int MAP_BITS = MAP_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_job_valid,
    input  t_job    i_job,
    output logic    o_job_pop,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result,
    output logic    o_clearing
);

    localparam int MAP_BYTES = MAP_BITS / 8;
    localparam int AW        = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(MAP_BYTES - 1);

    logic [7:0]    r_mem [MAP_BYTES];
    logic          r_clr_busy;
    logic [AW-1:0] r_clr_addr;
    logic          r_s1_valid;
    t_job          r_s1;
    logic [7:0]    r_rdata;
    logic          r_fw_valid;
    logic [AW-1:0] r_fw_addr;
    logic [7:0]    r_fw_data;
    logic          r_out_valid;
    t_result       r_out;

    logic          adv;
    logic          s1_done;
    logic          pop;
    logic [AW-1:0] s1_addr;
    logic [7:0]    cur;
    logic [7:0]    bmask;
    logic [7:0]    n_byte;
    logic          we;

    assign adv     = !r_out_valid || i_out_ready;
    assign s1_done = r_s1_valid && adv;
    assign pop     = !r_clr_busy && i_job_valid && (!r_s1_valid || adv);
    assign s1_addr = r_s1.addr[AW-1:0];

    // read data, with the write of the word just ahead forwarded
    assign cur   = (r_fw_valid && r_fw_addr == s1_addr) ? r_fw_data : r_rdata;
    assign bmask = 8'd1 << r_s1.bit_pos;
    assign n_byte = (r_s1.op == OP_CLEAR) ? (cur & ~bmask) : (cur | bmask);
    assign we     = s1_done && (r_s1.op == OP_SET || r_s1.op == OP_CLEAR);

    assign o_job_pop   = pop;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;
    assign o_clearing  = r_clr_busy;

    // bitmap ram: clearing sweep or read-modify-write, registered read
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= 8'd0;
        end else if (we) begin
            r_mem[s1_addr] <= n_byte;
        end
        if (pop) begin
            r_rdata <= r_mem[i_job.addr[AW-1:0]];
        end
    end

    // clearing pass after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == LAST_ADDR) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    // stage control, forwarding and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fw_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_done) begin
                r_s1_valid <= 1'b0;
            end
            if (we) begin
                r_fw_valid <= 1'b1;
            end
            if (s1_done) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1 <= i_job;
        end
        if (we) begin
            r_fw_addr <= s1_addr;
            r_fw_data <= n_byte;
        end
        if (s1_done) begin
            r_out.bit_value <= (r_s1.op == OP_TEST) && cur[r_s1.bit_pos];
            r_out.in_range  <= r_s1.in_range;
            r_out.kmer_code <= r_s1.kmer_code;
            r_out.complete  <= r_s1.complete;
        end
    end

endmodule

>>> hdl/kmer_presence_bitmap.sv
// k-mer presence bitmap
// input channel (i_in_valid / o_in_ready) takes one word per accepted cycle:
// a sequence character (kind 0) or a test, set or clear of one bitmap index.
// each accepted word gives exactly one result word on the output channel
// (o_out_valid / i_out_ready): test bit, range flag, window and k-mer flag.
// an accepted word passes queue, read stage and output register to
// o_out_valid; while the receiver is ready, throughput is one word per cycle,
// set by the ram's single read-modify-write port, with write forwarding.
// the front end updates the k-mer window and classifies each word, a
// two-entry queue decouples it from the back end that owns the ram.
// when the receiver stalls, the output register holds its word, the back
// end stops, the queue fills and o_in_ready drops; no word is lost.
// after reset the ram is swept to zero, one byte a cycle over MAP_BITS/8
// bytes (8192 at the default size); o_in_ready stays low during the sweep.
// registers on the apb port: kmer_length at 0x0, capacity_bits at 0x4;
// write them only while the block is idle.
module kmer_presence_bitmap
    import kpb_pkg::*;
#(
    parameter int MAP_BITS = MAP_BITS_DEF,
    parameter int MAX_KMER = MAX_KMER_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_symbol,
    input  logic        i_first_of_sequence,
    input  logic [15:0] i_bit_index,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_bit_value,
    output logic        o_index_in_range,
    output logic [31:0] o_kmer_code,
    output logic        o_kmer_complete,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [4:0]  r_kmer_length;
    logic [15:0] r_capacity_bits;

    t_job    front_job;
    t_job    q_job;
    t_result result;
    logic    q_full;
    logic    q_empty;
    logic    q_pop;
    logic    clearing;
    logic    accept;

    assign pready = 1'b1;

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kmer_length   <= KMER_LEN_RST;
            r_capacity_bits <= CAP_RST;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_KMER_LENGTH) begin
                r_kmer_length <= pwdata[4:0];
            end else begin
                r_capacity_bits <= pwdata[15:0];
            end
        end
    end

    // register read
    assign prdata = (paddr[2] == REG_CAPACITY) ? {16'd0, r_capacity_bits}
                                               : {27'd0, r_kmer_length};

    assign o_in_ready = !clearing && !q_full;
    assign accept     = i_in_valid && o_in_ready;

    kpb_front #(
        .MAP_BITS (MAP_BITS),
        .MAX_KMER (MAX_KMER)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_in_valid),
        .i_accept            (o_in_ready),
        .i_kind              (i_kind),
        .i_symbol            (i_symbol),
        .i_first_of_sequence (i_first_of_sequence),
        .i_bit_index         (i_bit_index),
        .i_kmer_length       (r_kmer_length),
        .i_capacity_bits     (r_capacity_bits),
        .o_job               (front_job)
    );

    kpb_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (accept),
        .i_data  (front_job),
        .o_full  (q_full),
        .o_empty (q_empty),
        .i_pop   (q_pop),
        .o_data  (q_job)
    );

    kpb_back #(
        .MAP_BITS (MAP_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (result),
        .o_clearing  (clearing)
    );

    assign o_bit_value      = result.bit_value;
    assign o_index_in_range = result.in_range;
    assign o_kmer_code      = result.kmer_code;
    assign o_kmer_complete  = result.complete;

endmodule

>>> sim/kpb_checker.sv
`timescale 1ns / 100ps

module kpb_checker
    import kpb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_symbol,
    input  logic        i_first_of_sequence,
    input  logic [15:0] i_bit_index,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic        i_bit_value,
    input  logic        i_index_in_range,
    input  logic [31:0] i_kmer_code,
    input  logic        i_kmer_complete,
    input  logic        i_psel,
    input  logic        i_penable,
    input  logic        i_pwrite,
    input  logic [2:0]  i_paddr,
    input  logic [31:0] i_pwdata,
    input  logic        i_pready,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int MAP_BYTES = MAP_BITS_DEF / 8;

    // shadow copy of the bitmap, the window and the registers
    logic [7:0]  presence_map [MAP_BYTES];
    logic [31:0] window;
    int unsigned bases_in_window;
    logic [4:0]  kmer_len;
    logic [15:0] cap_bits;
    t_result     expected_words [$];

    // byte of this bit index lies in the part of the map in use
    function automatic logic in_map(input logic [31:0] bit_addr);
        logic [31:0] byte_addr;
        byte_addr = bit_addr >> 3;
        return (byte_addr <= 32'(cap_bits >> 3)) && (byte_addr < 32'(MAP_BYTES));
    endfunction

    // update the shadow state for one accepted word, queue the result it gives
    task automatic predict_word(input t_kind kind, input logic [7:0] sym,
                                input logic first, input logic [15:0] idx);
        t_result     res;
        logic [2:0]  code;
        int unsigned k;
        logic [63:0] mask;
        res = '0;
        if (kind == KIND_BASE) begin
            k = (kmer_len == 0) ? 1 : (kmer_len > MAX_KMER_DEF) ? MAX_KMER_DEF : kmer_len;
            if (first) begin
                window = '0;
                bases_in_window = 0;
            end
            // nt4 encoding, raw 0..3 pass through as codes
            case (sym)
                8'd0, "A", "a":           code = 3'd0;
                8'd1, "C", "c":           code = 3'd1;
                8'd2, "G", "g":           code = 3'd2;
                8'd3, "T", "t", "U", "u": code = 3'd3;
                default:                  code = 3'b100;
            endcase
            // skipped bytes leave window and count alone
            if (!code[2]) begin
                mask = (64'd1 << (2 * k)) - 64'd1;
                window = ((window << 2) | 32'(code[1:0])) & mask[31:0];
                if (bases_in_window < k) bases_in_window++;
                if (bases_in_window >= k && in_map(window)) begin
                    presence_map[window >> 3][window[2:0]] = 1'b1;
                    res.in_range = 1'b1;
                    res.complete = 1'b1;
                end
            end
        end else if (in_map(32'(idx))) begin
            res.in_range = 1'b1;
            case (kind)
                KIND_TEST: res.bit_value = presence_map[idx >> 3][idx[2:0]];
                KIND_SET:  presence_map[idx >> 3][idx[2:0]] = 1'b1;
                default:   presence_map[idx >> 3][idx[2:0]] = 1'b0;
            endcase
        end
        res.kmer_code = window;
        expected_words.push_back(res);
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            foreach (presence_map[a]) presence_map[a] = '0;
            window = '0;
            bases_in_window = 0;
            kmer_len = KMER_LEN_RST;
            cap_bits = CAP_RST;
            expected_words.delete();
            o_fail_count = 0;
        end else begin
            // result word against the oldest prediction
            if (i_out_valid && i_out_ready) begin
                if (expected_words.size() == 0) begin
                    $error("result word with none expected, kmer_code %h", i_kmer_code);
                    o_fail_count++;
                end else begin
                    want = expected_words.pop_front();
                    if (i_bit_value !== want.bit_value) begin
                        $error("bit_value: expected %0d, got %0d", want.bit_value,
                               i_bit_value);
                        o_fail_count++;
                    end
                    if (i_index_in_range !== want.in_range) begin
                        $error("index_in_range: expected %0d, got %0d", want.in_range,
                               i_index_in_range);
                        o_fail_count++;
                    end
                    if (i_kmer_code !== want.kmer_code) begin
                        $error("kmer_code: expected %h, got %h", want.kmer_code,
                               i_kmer_code);
                        o_fail_count++;
                    end
                    if (i_kmer_complete !== want.complete) begin
                        $error("kmer_complete: expected %0d, got %0d", want.complete,
                               i_kmer_complete);
                        o_fail_count++;
                    end
                end
            end
            // register writes
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                if (i_paddr[2] == REG_KMER_LENGTH) kmer_len = i_pwdata[4:0];
                else cap_bits = i_pwdata[15:0];
            end
            // input word
            if (i_in_valid && i_in_ready) begin
                predict_word(t_kind'(i_kind), i_symbol, i_first_of_sequence, i_bit_index);
            end
        end
        o_pending = expected_words.size();
    end

endmodule

>>> sim/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import kpb_pkg::*;

    localparam int WORDS_PER_PHASE = 225;
    localparam int N_FIXED = 7;
    localparam int N_PHASES = 8;
    localparam int LATENCY = 2;
    // covers the ram sweep after reset several times over
    localparam int WATCHDOG_LIMIT = 50000;
    localparam logic [2:0] ADDR_KMER_LENGTH = {REG_KMER_LENGTH, 2'b00};
    localparam logic [2:0] ADDR_CAPACITY = {REG_CAPACITY, 2'b00};

    // register settings per phase, phases past the table draw their own
    localparam logic [4:0] PHASE_KMER [N_FIXED] = '{
        5'd1, 5'd16, 5'd0, 5'd31, 5'd4, 5'd2, 5'd12
    };
    localparam logic [15:0] PHASE_CAP [N_FIXED] = '{
        16'd0, 16'hffff, 16'd7, 16'd4096, 16'd300, 16'hffff, 16'd40000
    };

    // characters of a well-formed sequence
    localparam logic [7:0] BASE_CHARS [14] = '{
        "A", "C", "G", "T", "a", "c", "g", "t", "U", "u", 8'd0, 8'd1, 8'd2, 8'd3
    };

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_PERIODIC,
        RX_BLOCKED
    } t_rx_mode;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [1:0]  in_kind = KIND_BASE;
    logic [7:0]  in_symbol = 8'd0;
    logic        in_first = 1'b0;
    logic [15:0] in_bit_index = 16'd0;
    logic        out_valid;
    logic        rx_ready = 1'b0;
    logic        bit_value;
    logic        index_in_range;
    logic [31:0] kmer_code;
    logic        kmer_complete;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;

    int          burst_left = 0;
    int          seq_left = 0;
    logic [4:0]  cur_k = KMER_LEN_RST;
    logic [15:0] cur_cap = CAP_RST;
    logic [15:0] last_set_idx = 16'd0;
    t_rx_mode    rx_mode = RX_OPEN;
    int          rx_mode_left = 0;
    int          rx_hold = 0;
    int unsigned rx_tick = 0;
    int          idle_cycles = 0;

    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    kmer_presence_bitmap u_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .o_in_ready          (in_ready),
        .i_kind              (in_kind),
        .i_symbol            (in_symbol),
        .i_first_of_sequence (in_first),
        .i_bit_index         (in_bit_index),
        .o_out_valid         (out_valid),
        .i_out_ready         (rx_ready),
        .o_bit_value         (bit_value),
        .o_index_in_range    (index_in_range),
        .o_kmer_code         (kmer_code),
        .o_kmer_complete     (kmer_complete),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    kpb_checker u_check (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_in_valid          (in_valid),
        .i_in_ready          (in_ready),
        .i_kind              (in_kind),
        .i_symbol            (in_symbol),
        .i_first_of_sequence (in_first),
        .i_bit_index         (in_bit_index),
        .i_out_valid         (out_valid),
        .i_out_ready         (rx_ready),
        .i_bit_value         (bit_value),
        .i_index_in_range    (index_in_range),
        .i_kmer_code         (kmer_code),
        .i_kmer_complete     (kmer_complete),
        .i_psel              (psel),
        .i_penable           (penable),
        .i_pwrite            (pwrite),
        .i_paddr             (paddr),
        .i_pwdata            (pwdata),
        .i_pready            (pready),
        .o_fail_count        (fail_count),
        .o_pending           (pending)
    );

    // setup then access cycle
    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // one input word, opening a new burst after a random gap when the last ran out
    task automatic send_word(input t_kind kind, input logic [7:0] sym,
                             input logic first, input logic [15:0] idx);
        int unsigned gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge clk);
                in_valid <= 1'b0;
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
        end
        burst_left--;
        @(negedge clk);
        in_valid <= 1'b1;
        in_kind <= kind;
        in_symbol <= sym;
        in_first <= first;
        in_bit_index <= idx;
        do @(posedge clk); while (!in_ready);
    endtask

    // hold the sender until every result word is back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge clk);
        repeat (LATENCY) @(negedge clk);
    endtask

    // index for test, set and clear: small, near the capacity edge, recently set,
    // inside the k-mer space, or anywhere
    function automatic logic [15:0] pick_index();
        int unsigned k_eff;
        logic [15:0] idx;
        k_eff = (cur_k == 0) ? 1 : (cur_k > MAX_KMER_DEF) ? MAX_KMER_DEF : cur_k;
        case ($urandom_range(0, 4))
            0: idx = 16'($urandom_range(0, 255));
            1: idx = {cur_cap[15:3], 3'b000} + 16'($urandom_range(0, 15)) - 16'd8;
            2: idx = last_set_idx;
            3: idx = (k_eff >= 8) ? 16'($urandom)
                                  : 16'($urandom_range(0, (1 << (2 * k_eff)) - 1));
            default: idx = 16'($urandom);
        endcase
        return idx;
    endfunction

    task automatic random_word();
        t_kind       kind;
        logic [7:0]  sym;
        logic        first;
        logic [15:0] idx;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        sym = 8'($urandom);
        idx = 16'($urandom);
        first = 1'b0;
        if (roll < 70) begin
            // well-formed sequence, an odd stray byte inside
            kind = KIND_BASE;
            if (seq_left == 0) begin
                seq_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6)
                                                        : $urandom_range(10, 60);
                first = 1'b1;
            end
            seq_left--;
            if ($urandom_range(0, 19) != 0) sym = BASE_CHARS[$urandom_range(0, 13)];
        end else if (roll < 78) begin
            // any byte, start flag at random
            kind = KIND_BASE;
            first = 1'($urandom_range(0, 1));
        end else begin
            kind = t_kind'($urandom_range(1, 3));
            idx = pick_index();
            first = 1'($urandom_range(0, 1));
            if (kind == KIND_SET) last_set_idx = idx;
        end
        send_word(kind, sym, first, idx);
    endtask

    // receiver stall pattern, switching mode every so often
    always @(negedge clk) begin
        if (rx_mode_left == 0) begin
            rx_mode = t_rx_mode'($urandom_range(0, 3));
            rx_mode_left = $urandom_range(20, 200);
        end
        rx_mode_left--;
        rx_tick++;
        case (rx_mode)
            RX_OPEN:     rx_ready <= 1'b1;
            RX_COIN:     rx_ready <= 1'($urandom_range(0, 1));
            RX_PERIODIC: rx_ready <= (rx_tick % 3) != 0;
            default: begin
                if (rx_hold != 0) begin
                    rx_hold--;
                    rx_ready <= 1'b0;
                end else begin
                    rx_ready <= 1'b1;
                    if ($urandom_range(0, 9) == 0) rx_hold = $urandom_range(5, 30);
                end
            end
        endcase
    end

    // watchdog on cycles with no word moving on either channel
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && rx_ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed words on a tiny map: k of 2, bits 0..23 in use
        cur_k = 5'd2;
        cur_cap = 16'd23;
        apb_write(ADDR_KMER_LENGTH, 32'(cur_k));
        apb_write(ADDR_CAPACITY, 32'(cur_cap));
        send_word(KIND_SET, 8'hff, 1'b1, 16'd0);
        send_word(KIND_TEST, 8'd0, 1'b0, 16'd0);
        send_word(KIND_CLEAR, 8'd0, 1'b0, 16'd0);
        send_word(KIND_TEST, 8'd0, 1'b0, 16'd0);
        send_word(KIND_SET, 8'd0, 1'b0, 16'hffff);
        send_word(KIND_TEST, 8'd0, 1'b0, 16'hffff);
        send_word(KIND_SET, 8'd0, 1'b0, 16'd23);
        send_word(KIND_TEST, 8'd0, 1'b0, 16'd23);
        send_word(KIND_SET, 8'd0, 1'b0, 16'd24);
        // every base letter, both cases, and raw codes 0 and 3
        send_word(KIND_BASE, "A", 1'b1, 16'hffff);
        send_word(KIND_BASE, "c", 1'b0, 16'd0);
        send_word(KIND_BASE, "G", 1'b0, 16'd0);
        send_word(KIND_BASE, "t", 1'b0, 16'd0);
        send_word(KIND_BASE, "U", 1'b0, 16'd0);
        send_word(KIND_BASE, "u", 1'b0, 16'd0);
        send_word(KIND_BASE, "a", 1'b0, 16'd0);
        send_word(KIND_BASE, "C", 1'b0, 16'd0);
        send_word(KIND_BASE, "g", 1'b0, 16'd0);
        send_word(KIND_BASE, "T", 1'b0, 16'd0);
        send_word(KIND_BASE, 8'd0, 1'b0, 16'd0);
        send_word(KIND_BASE, 8'd3, 1'b0, 16'd0);
        // skipped bytes keep the window, a start flag on one still clears it
        send_word(KIND_BASE, "N", 1'b0, 16'd0);
        send_word(KIND_BASE, 8'hff, 1'b0, 16'd0);
        send_word(KIND_BASE, "N", 1'b1, 16'd0);
        send_word(KIND_BASE, "G", 1'b0, 16'd0);
        send_word(KIND_BASE, "T", 1'b0, 16'd0);
        send_word(KIND_TEST, 8'd0, 1'b1, 16'd11);

        // random phases, one register setting each
        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            if (p < N_FIXED) begin
                cur_k = PHASE_KMER[p];
                cur_cap = PHASE_CAP[p];
            end else begin
                cur_k = 5'($urandom_range(1, MAX_KMER_DEF));
                cur_cap = 16'($urandom);
            end
            apb_write(ADDR_KMER_LENGTH, 32'(cur_k));
            apb_write(ADDR_CAPACITY, 32'(cur_cap));
            seq_left = 0;
            repeat (WORDS_PER_PHASE) random_word();
        end

        drain_results();
        repeat (LATENCY + 8) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> files.f
hdl/kpb_pkg.sv
hdl/kpb_queue.sv
hdl/kpb_front.sv
hdl/kpb_back.sv
hdl/kmer_presence_bitmap.sv
sim/kpb_checker.sv
sim/testbench.sv
